/* design/cfoc_pkg.sv */
// shared constants, operation codes and controller/datapath signal groups
package cfoc_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 7;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_CHECK   = 2'd3
    } t_op;

    typedef struct packed {
        logic exec;
        logic start;
        logic walk;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic walk_done;
    } t_status;

endpackage

/* design/cfoc_if.sv */
// request and response channel interfaces
interface cfoc_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  op;
    logic [cfoc_pkg::VALUE_W-1:0] entry_value;

    modport source (output valid, output op, output entry_value, input ready);
    modport sink (input valid, input op, input entry_value, output ready);
    modport monitor (input valid, input ready, input op, input entry_value);
endinterface

interface cfoc_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         accepted;
    logic [cfoc_pkg::COUNT_W-1:0] entry_count;
    logic                         is_empty;
    logic [cfoc_pkg::VALUE_W-1:0] front_value;
    logic                         front_valid;
    logic                         in_order;

    modport source (
        output valid, output accepted, output entry_count, output is_empty,
        output front_value, output front_valid, output in_order, input ready
    );
    modport sink (
        input valid, input accepted, input entry_count, input is_empty,
        input front_value, input front_valid, input in_order, output ready
    );
    modport monitor (
        input valid, input ready, input accepted, input entry_count, input is_empty,
        input front_value, input front_valid, input in_order
    );
endinterface

/* design/cfoc_ctrl.sv */
// controller state machine: accept, walk the stored entries, deliver the result
module cfoc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  cfoc_pkg::t_status i_status,
    output cfoc_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WALK,
        S_RESULT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd       = '0;
        o_cmd.exec  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.start = (r_state == S_START);
        o_cmd.walk  = (r_state == S_WALK);
        o_cmd.load  = (r_state == S_RESULT) && w_slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_START;
                end
                S_START: r_state <= S_WALK;
                S_WALK: begin
                    if (i_status.walk_done) r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (w_slot_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* design/cfoc_datapath.sv */
// queue indices, entry memory, order compare and result register
module cfoc_datapath #(
    parameter int CAPACITY   = cfoc_pkg::CAPACITY,
    parameter int DATA_WIDTH = cfoc_pkg::DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cfoc_pkg::t_cmd               i_cmd,
    output cfoc_pkg::t_status            o_status,
    input  logic [1:0]                   i_op,
    input  logic [cfoc_pkg::VALUE_W-1:0] i_entry_value,
    output logic                         o_accepted,
    output logic [cfoc_pkg::COUNT_W-1:0] o_entry_count,
    output logic                         o_is_empty,
    output logic [cfoc_pkg::VALUE_W-1:0] o_front_value,
    output logic                         o_front_valid,
    output logic                         o_in_order
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [DATA_WIDTH-1:0] mem [CAPACITY];

    logic [AW-1:0]         r_front;
    logic [AW-1:0]         r_back;
    logic [CW-1:0]         r_count;
    logic [AW-1:0]         r_walk;
    logic [CW-1:0]         r_left;
    logic                  r_pend;

    cfoc_pkg::t_op         w_op;
    cfoc_pkg::t_op         r_op;
    logic                  w_full;
    logic                  w_acc;
    logic [AW-1:0]         w_next_back;
    logic [63:0]           w_value_ext;
    logic [63:0]           w_front_ext;
    logic                  r_acc;
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic [DATA_WIDTH-1:0] r_prev;
    logic [DATA_WIDTH-1:0] r_front_data;
    logic                  r_first;
    logic                  r_order;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i_idx);
        return (i_idx == AW'(CAPACITY - 1)) ? '0 : i_idx + 1'b1;
    endfunction

    assign w_op        = cfoc_pkg::t_op'(i_op);
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_next_back = next_slot(r_back);
    assign w_value_ext = 64'(i_entry_value);
    assign w_front_ext = 64'(r_front_data);

    always_comb begin
        case (w_op)
            cfoc_pkg::OP_ENQUEUE: w_acc = !w_full;
            cfoc_pkg::OP_DEQUEUE: w_acc = (r_count != '0);
            default:              w_acc = 1'b1;
        endcase
    end

    assign o_status.walk_done = (r_left == '0) && !r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= AW'(CAPACITY - 1);
            r_count <= '0;
            r_walk  <= '0;
            r_left  <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                case (w_op)
                    cfoc_pkg::OP_ENQUEUE: begin
                        if (!w_full) begin
                            r_back  <= w_next_back;
                            r_count <= r_count + 1'b1;
                        end
                    end
                    cfoc_pkg::OP_DEQUEUE: begin
                        if (r_count != '0) begin
                            r_front <= next_slot(r_front);
                            r_count <= r_count - 1'b1;
                        end
                    end
                    cfoc_pkg::OP_CLEAR: begin
                        r_front <= '0;
                        r_back  <= AW'(CAPACITY - 1);
                        r_count <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.start) begin
                r_walk <= r_front;
                r_left <= (r_op == cfoc_pkg::OP_CHECK) ? r_count : CW'(r_count != '0);
                r_pend <= 1'b0;
            end
            if (i_cmd.walk) begin
                r_pend <= (r_left != '0);
                if (r_left != '0) begin
                    r_walk <= next_slot(r_walk);
                    r_left <= r_left - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_op  <= w_op;
            r_acc <= w_acc;
            if ((w_op == cfoc_pkg::OP_ENQUEUE) && !w_full) begin
                mem[w_next_back] <= w_value_ext[DATA_WIDTH-1:0];
            end
        end
        if (i_cmd.start) begin
            r_first <= 1'b1;
            r_order <= 1'b1;
        end
        if (i_cmd.walk) begin
            if (r_left != '0) r_rd_data <= mem[r_walk];
            if (r_pend) begin
                if (r_first) begin
                    r_front_data <= r_rd_data;
                    r_first      <= 1'b0;
                end else if (r_rd_data > r_prev) begin
                    r_order <= 1'b0;
                end
                r_prev <= r_rd_data;
            end
        end
        if (i_cmd.load) begin
            o_accepted    <= r_acc;
            o_entry_count <= cfoc_pkg::COUNT_W'(r_count);
            o_is_empty    <= (r_count == '0);
            o_front_valid <= (r_count != '0);
            o_front_value <= (r_count != '0) ? w_front_ext[cfoc_pkg::VALUE_W-1:0] : '0;
            o_in_order    <= (r_op == cfoc_pkg::OP_CHECK) && r_order;
        end
    end

endmodule

/* design/circular_fifo_with_order_check.sv */
// top level: circular fifo of data words with an order check
//
// i_req carries one operation per beat (op, entry_value): enqueue, dequeue,
// clear, or check that the held entries never rise from front to back.
// o_rsp returns exactly one beat per request with the accepted flag, the
// entry count, the empty flag, the front entry with its valid flag and the
// order flag of a check.
// Requests are taken one at a time: i_req.ready is high only while no
// operation is in progress. After an accepted beat the entries are read from
// the single read port of the entry memory, one per cycle: the front entry
// alone for enqueue and dequeue, all held entries for a check.
// After acceptance the controller steps through a start state, a walk state
// that reads the entries and a result state that loads the response
// register once that register is free. The next request is taken in the
// cycle after the response register loads.
// A stalled response is held in the output register while the next request
// is already accepted and worked on; only its own response waits.
// Reset empties the queue at once; the stored words are undefined.
module circular_fifo_with_order_check #(
    parameter int CAPACITY   = cfoc_pkg::CAPACITY,
    parameter int DATA_WIDTH = cfoc_pkg::DATA_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cfoc_req_if.sink   i_req,
    cfoc_rsp_if.source o_rsp
);

    cfoc_pkg::t_cmd    w_cmd;
    cfoc_pkg::t_status w_status;

    cfoc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    cfoc_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_op          (i_req.op),
        .i_entry_value (i_req.entry_value),
        .o_accepted    (o_rsp.accepted),
        .o_entry_count (o_rsp.entry_count),
        .o_is_empty    (o_rsp.is_empty),
        .o_front_value (o_rsp.front_value),
        .o_front_valid (o_rsp.front_valid),
        .o_in_order    (o_rsp.in_order)
    );

endmodule

/* design/cfoc_checker.sv */
// port-level checks for the circular fifo, bound to the top level
module cfoc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic                         i_rsp_accepted,
    input logic [cfoc_pkg::COUNT_W-1:0] i_rsp_entry_count,
    input logic                         i_rsp_is_empty,
    input logic [cfoc_pkg::VALUE_W-1:0] i_rsp_front_value,
    input logic                         i_rsp_front_valid
);

    // a stalled response beat holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_entry_count)
            && $stable(i_rsp_front_value) && $stable(i_rsp_accepted))
        else $error("response beat changed while stalled");

    // one operation in flight: no request taken right after another
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while an operation is in progress");

    a_empty_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_is_empty == (i_rsp_entry_count == '0))
            && (i_rsp_front_valid == !i_rsp_is_empty))
        else $error("empty and front flags disagree with entry count");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response beat right after reset");

endmodule

bind circular_fifo_with_order_check cfoc_checker u_cfoc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_accepted    (o_rsp.accepted),
    .i_rsp_entry_count (o_rsp.entry_count),
    .i_rsp_is_empty    (o_rsp.is_empty),
    .i_rsp_front_value (o_rsp.front_value),
    .i_rsp_front_valid (o_rsp.front_valid)
);

/* sim/circular_fifo_with_order_check_tb.sv */
// testbench for circular_fifo_with_order_check: directed table then random runs vs predictor
module circular_fifo_with_order_check_tb;

    localparam int ITEM_GOAL   = 1850;
    localparam int STALL_LIMIT = 2000;
    localparam int PRINT_CAP   = 40;
    localparam int ROW_COUNT   = 25;

    typedef struct packed {
        logic                         accepted;
        logic [cfoc_pkg::COUNT_W-1:0] entry_count;
        logic                         is_empty;
        logic [cfoc_pkg::VALUE_W-1:0] front_value;
        logic                         front_valid;
        logic                         in_order;
    } t_fifo_status;

    typedef struct {
        cfoc_pkg::t_op                op;
        logic [cfoc_pkg::VALUE_W-1:0] value;
        bit                           typed;
        t_fifo_status                 want;
    } t_step_row;

    logic i_clk;
    logic i_rst_n;

    cfoc_req_if req_if ();
    cfoc_rsp_if rsp_if ();

    circular_fifo_with_order_check dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // predictor state
    logic [cfoc_pkg::VALUE_W-1:0] word_store [cfoc_pkg::CAPACITY];
    int                           front_ix;
    int                           back_ix;
    int                           held_n;

    t_fifo_status status_due [$];
    int           mismatches;
    int           items_sent;
    int           quiet_cycles;
    bit           no_idle;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_fifo_status apply_fifo_op(cfoc_pkg::t_op op,
                                                   logic [cfoc_pkg::VALUE_W-1:0] value);
        t_fifo_status                 s;
        int                           slot;
        logic [cfoc_pkg::VALUE_W-1:0] last;
        s = '0;
        case (op)
            cfoc_pkg::OP_ENQUEUE: begin
                if (held_n < cfoc_pkg::CAPACITY) begin
                    back_ix = (back_ix + 1) % cfoc_pkg::CAPACITY;
                    word_store[back_ix] = value;
                    held_n++;
                    s.accepted = 1'b1;
                end
            end
            cfoc_pkg::OP_DEQUEUE: begin
                if (held_n != 0) begin
                    front_ix = (front_ix + 1) % cfoc_pkg::CAPACITY;
                    held_n--;
                    s.accepted = 1'b1;
                end
            end
            cfoc_pkg::OP_CLEAR: begin
                front_ix = 0;
                back_ix = cfoc_pkg::CAPACITY - 1;
                held_n = 0;
                s.accepted = 1'b1;
            end
            default: begin
                s.accepted = 1'b1;
                s.in_order = 1'b1;
                slot = front_ix;
                last = word_store[slot];
                for (int k = 1; k < held_n; k++) begin
                    slot = (slot + 1) % cfoc_pkg::CAPACITY;
                    if (word_store[slot] > last) s.in_order = 1'b0;
                    last = word_store[slot];
                end
            end
        endcase
        s.entry_count = held_n[cfoc_pkg::COUNT_W-1:0];
        s.is_empty = (held_n == 0);
        if (held_n != 0) begin
            s.front_value = word_store[front_ix];
            s.front_valid = 1'b1;
        end
        return s;
    endfunction

    task automatic flag_mismatch(string what, logic [cfoc_pkg::VALUE_W-1:0] got,
                                 logic [cfoc_pkg::VALUE_W-1:0] want);
        if (mismatches < PRINT_CAP) begin
            $display("%0t %s: got %0h, due %0h", $time, what, got, want);
        end
        mismatches++;
    endtask

    task automatic push_op(cfoc_pkg::t_op op, logic [cfoc_pkg::VALUE_W-1:0] value,
                           bit typed = 1'b0, t_fifo_status typed_want = '0);
        int           gap;
        t_fifo_status due;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.op <= op;
        req_if.entry_value <= value;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        due = apply_fifo_op(op, value);
        status_due.push_back(typed ? typed_want : due);
        items_sent++;
    endtask

    // response side: random stalls per beat
    initial begin
        int stall;
        rsp_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!(rsp_if.valid && rsp_if.ready)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_fifo_status want;
        bit           req_beat;
        bit           rsp_beat;
        req_beat = req_if.valid && req_if.ready;
        rsp_beat = rsp_if.valid && rsp_if.ready;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (rsp_beat) begin
                if (status_due.size() == 0) begin
                    flag_mismatch("beat with nothing due", rsp_if.front_value, '0);
                end else begin
                    want = status_due.pop_front();
                    if (rsp_if.accepted !== want.accepted)
                        flag_mismatch("accepted", cfoc_pkg::VALUE_W'(rsp_if.accepted),
                                      cfoc_pkg::VALUE_W'(want.accepted));
                    if (rsp_if.entry_count !== want.entry_count)
                        flag_mismatch("entry_count", cfoc_pkg::VALUE_W'(rsp_if.entry_count),
                                      cfoc_pkg::VALUE_W'(want.entry_count));
                    if (rsp_if.is_empty !== want.is_empty)
                        flag_mismatch("is_empty", cfoc_pkg::VALUE_W'(rsp_if.is_empty),
                                      cfoc_pkg::VALUE_W'(want.is_empty));
                    if (rsp_if.front_value !== want.front_value)
                        flag_mismatch("front_value", rsp_if.front_value, want.front_value);
                    if (rsp_if.front_valid !== want.front_valid)
                        flag_mismatch("front_valid", cfoc_pkg::VALUE_W'(rsp_if.front_valid),
                                      cfoc_pkg::VALUE_W'(want.front_valid));
                    if (rsp_if.in_order !== want.in_order)
                        flag_mismatch("in_order", cfoc_pkg::VALUE_W'(rsp_if.in_order),
                                      cfoc_pkg::VALUE_W'(want.in_order));
                end
            end
            quiet_cycles <= (req_beat || rsp_beat) ? 0 : quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("circular_fifo_with_order_check: mismatch");
        $finish;
    end

    initial begin
        t_step_row                    opening_rows [ROW_COUNT];
        int                           kind;
        int                           n;
        logic [cfoc_pkg::VALUE_W-1:0] v;
        logic [cfoc_pkg::VALUE_W-1:0] dec;

        opening_rows = '{
            '{cfoc_pkg::OP_DEQUEUE, 32'h0000_0000, 1'b1,
              '{1'b0, 7'd0, 1'b1, 32'h0, 1'b0, 1'b0}},
            '{cfoc_pkg::OP_CHECK,   32'h0000_0000, 1'b1,
              '{1'b1, 7'd0, 1'b1, 32'h0, 1'b0, 1'b1}},
            '{cfoc_pkg::OP_CLEAR,   32'hFFFF_FFFF, 1'b1,
              '{1'b1, 7'd0, 1'b1, 32'h0, 1'b0, 1'b0}},
            '{cfoc_pkg::OP_ENQUEUE, 32'hFFFF_FFFF, 1'b1,
              '{1'b1, 7'd1, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0}},
            '{cfoc_pkg::OP_CHECK,   32'h0000_0000, 1'b1,
              '{1'b1, 7'd1, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1}},
            '{cfoc_pkg::OP_ENQUEUE, 32'hFFFF_FFFF, 1'b0, '0},
            '{cfoc_pkg::OP_ENQUEUE, 32'h0000_0000, 1'b0, '0},
            '{cfoc_pkg::OP_CHECK,   32'h0000_0000, 1'b0, '0},
            '{cfoc_pkg::OP_ENQUEUE, 32'h0000_0001, 1'b0, '0},
            '{cfoc_pkg::OP_CHECK,   32'hFFFF_FFFF, 1'b0, '0},
            '{cfoc_pkg::OP_DEQUEUE, 32'hFFFF_FFFF, 1'b0, '0},
            '{cfoc_pkg::OP_DEQUEUE, 32'h0000_0000, 1'b0, '0},
            '{cfoc_pkg::OP_CHECK,   32'h0000_0000, 1'b0, '0},
            '{cfoc_pkg::OP_DEQUEUE, 32'h0000_0000, 1'b0, '0},
            '{cfoc_pkg::OP_CHECK,   32'h0000_0000, 1'b0, '0},
            '{cfoc_pkg::OP_DEQUEUE, 32'h0000_0000, 1'b0, '0},
            '{cfoc_pkg::OP_DEQUEUE, 32'hFFFF_FFFF, 1'b1,
              '{1'b0, 7'd0, 1'b1, 32'h0, 1'b0, 1'b0}},
            '{cfoc_pkg::OP_ENQUEUE, 32'h8000_0000, 1'b0, '0},
            '{cfoc_pkg::OP_CLEAR,   32'h0000_0000, 1'b1,
              '{1'b1, 7'd0, 1'b1, 32'h0, 1'b0, 1'b0}},
            '{cfoc_pkg::OP_ENQUEUE, 32'h7FFF_FFFF, 1'b0, '0},
            '{cfoc_pkg::OP_ENQUEUE, 32'h5555_5555, 1'b0, '0},
            '{cfoc_pkg::OP_ENQUEUE, 32'hAAAA_AAAA, 1'b0, '0},
            '{cfoc_pkg::OP_CHECK,   32'h0000_0000, 1'b0, '0},
            '{cfoc_pkg::OP_CLEAR,   32'hFFFF_FFFF, 1'b1,
              '{1'b1, 7'd0, 1'b1, 32'h0, 1'b0, 1'b0}},
            '{cfoc_pkg::OP_CHECK,   32'hFFFF_FFFF, 1'b1,
              '{1'b1, 7'd0, 1'b1, 32'h0, 1'b0, 1'b1}}
        };

        mismatches = 0;
        items_sent = 0;
        no_idle = 1'b0;
        front_ix = 0;
        back_ix = cfoc_pkg::CAPACITY - 1;
        held_n = 0;
        i_rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.op <= cfoc_pkg::OP_ENQUEUE;
        req_if.entry_value <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_rows[r]) begin
            push_op(opening_rows[r].op, opening_rows[r].value, opening_rows[r].typed,
                    opening_rows[r].want);
        end

        while (items_sent < ITEM_GOAL) begin
            no_idle = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 11);
            case (kind)
                0, 1, 2, 3, 4: begin
                    // non-increasing run, sometimes broken, then checked
                    n = $urandom_range(1, 70);
                    v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom;
                    for (int k = 0; k < n; k++) begin
                        if ($urandom_range(0, 11) == 0) v = $urandom;
                        push_op(cfoc_pkg::OP_ENQUEUE, v);
                        case ($urandom_range(0, 2))
                            0: dec = '0;
                            1: dec = $urandom_range(1, 15);
                            default: dec = $urandom >> $urandom_range(0, 31);
                        endcase
                        if (dec > v) dec = v;
                        v = v - dec;
                    end
                    push_op(cfoc_pkg::OP_CHECK, $urandom);
                    if ($urandom_range(0, 1) == 1) begin
                        repeat ($urandom_range(1, 6)) push_op(cfoc_pkg::OP_DEQUEUE, $urandom);
                        push_op(cfoc_pkg::OP_CHECK, $urandom);
                    end
                end
                8: begin
                    n = held_n + 1;
                    repeat (n) push_op(cfoc_pkg::OP_DEQUEUE, $urandom);
                    push_op(cfoc_pkg::OP_CHECK, $urandom);
                end
                9: begin
                    push_op(cfoc_pkg::OP_CLEAR, $urandom);
                    push_op(cfoc_pkg::OP_CHECK, $urandom);
                end
                10: begin
                    // fill up, then beats against a full queue
                    while (held_n < cfoc_pkg::CAPACITY) begin
                        push_op(cfoc_pkg::OP_ENQUEUE,
                                $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom);
                    end
                    repeat ($urandom_range(1, 3)) push_op(cfoc_pkg::OP_ENQUEUE, $urandom);
                    push_op(cfoc_pkg::OP_CHECK, $urandom);
                end
                default: begin
                    repeat ($urandom_range(5, 30)) begin
                        push_op(cfoc_pkg::t_op'($urandom_range(0, 3)), $urandom);
                    end
                end
            endcase
        end

        req_if.valid <= 1'b0;
        while (status_due.size() != 0) @(posedge i_clk);
        repeat (cfoc_pkg::CAPACITY + 16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("circular_fifo_with_order_check: match");
        end else begin
            $display("circular_fifo_with_order_check: mismatch");
        end
        $finish;
    end

endmodule

/* sim.f */
design/cfoc_pkg.sv
design/cfoc_if.sv
design/cfoc_ctrl.sv
design/cfoc_datapath.sv
design/circular_fifo_with_order_check.sv
design/cfoc_checker.sv
sim/circular_fifo_with_order_check_tb.sv
